// File: sv/assert_macros.svh
// Assertion macros shared by the colormap RTL.
// No dependencies; included by the files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked in the same cycle, disabled during reset.
`define SCM_ASSERT_SAME(lbl, clk_s, rstn_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!(rstn_s)) (ante) |-> (cons)) \
    else $error("colormap assertion failed");

// Implication checked in the cycle after the antecedent, disabled during reset.
`define SCM_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!(rstn_s)) (ante) |=> (cons)) \
    else $error("colormap assertion failed");

`endif

// File: sv/scm_pkg.sv
// Shared constants and types of the scalar-to-rainbow colormap.
// No dependencies; used by the channel interfaces and the top level.
package scm_pkg;

  localparam int SAMPLE_WIDTH_DEF  = 32;
  localparam int FRACTION_BITS_DEF = 10;

  // Configuration register indexes
  localparam int CFG_INDEX_WIDTH = 1;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_LOW_VALUE  = 1'b0;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_HIGH_VALUE = 1'b1;

  // Reset value of high_value before truncation to the sample width
  localparam int HIGH_RESET = 4095;

  localparam int COLOR_WIDTH = 8;
  localparam logic [COLOR_WIDTH-1:0] COLOR_FULL = 8'd255;
  localparam logic [COLOR_WIDTH-1:0] COLOR_NONE = 8'd0;

  // Sample class decided at the first stage
  typedef enum logic [1:0] {
    CLS_RAMP = 2'd0,
    CLS_BLUE = 2'd1,
    CLS_RED  = 2'd2
  } cls_t;

endpackage

// File: sv/scm_if.sv
// Valid/ready channel interfaces: sample stream in, pixel stream out.
// Depends on scm_pkg for width defaults.
interface scm_sample_if
  import scm_pkg::*;
#(
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] sample;
  logic                           last_sample;

  modport source (output valid, output sample, output last_sample, input ready);
  modport sink   (input valid, input sample, input last_sample, output ready);
endinterface

interface scm_pixel_if
  import scm_pkg::*;
();
  logic                   valid;
  logic                   ready;
  logic [COLOR_WIDTH-1:0] red;
  logic [COLOR_WIDTH-1:0] green;
  logic [COLOR_WIDTH-1:0] blue;
  logic                   last_pixel;

  modport source (output valid, output red, output green, output blue,
                  output last_pixel, input ready);
  modport sink   (input valid, input red, input green, input blue,
                  input last_pixel, output ready);
endinterface

// File: sv/scalar_to_rainbow_colormap.sv
// Top level of the scalar-to-rainbow colormap: classify, pipelined divider, color stage.
// Depends on scm_pkg, scm_if.sv and assert_macros.svh.
// Registers in order: first stage, divider stages, output register; one restoring-division
// step per pipeline stage. Throughput: one sample per clock unless the output stalls.
// Each stage holds its item while the next one is full, so stalls lose nothing.
// Reset (rst_n low, synchronous): all stage valids clear, low_value = 0, high_value = 4095.
`include "assert_macros.svh"

module scalar_to_rainbow_colormap
  import scm_pkg::*;
#(
  parameter int SAMPLE_WIDTH  = SAMPLE_WIDTH_DEF,
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  scm_sample_if.sink                 in_ch,
  scm_pixel_if.source                out_ch,
  input  logic                       cfg_we,
  input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [SAMPLE_WIDTH-1:0]    cfg_data
);

  localparam int QB = FRACTION_BITS + 2;   // quotient bits, one per divider stage
  localparam int RW = FRACTION_BITS + 9;   // width of the ramp product
  localparam logic [SAMPLE_WIDTH-1:0] SIGN_BIT = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
  localparam logic [FRACTION_BITS:0]  SEG_ONE  = {1'b1, {FRACTION_BITS{1'b0}}};
  localparam logic [RW-1:0]           HALF     = RW'(SEG_ONE >> 1);

  // Configuration registers
  logic [SAMPLE_WIDTH-1:0] low_r, high_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_r  <= '0;
      high_r <= SAMPLE_WIDTH'(HIGH_RESET);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_LOW_VALUE:  low_r  <= cfg_data;
        REG_HIGH_VALUE: high_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Pipeline registers: stage k holds the divider state after k steps
  logic                    vld_r  [QB+1];
  cls_t                    cls_r  [QB+1];
  logic [SAMPLE_WIDTH-1:0] rem_r  [QB+1];
  logic [SAMPLE_WIDTH-1:0] span_r [QB+1];
  logic [QB-1:0]           quo_r  [QB+1];
  logic                    last_r [QB+1];

  logic                    rem_nxt [QB+1];
  logic                    take    [QB+1];
  cls_t                    cls_nxt [QB+1];
  logic [SAMPLE_WIDTH-1:0] remv_nxt [QB+1];
  logic [QB-1:0]           quo_nxt [QB+1];

  logic                    out_vld_r, out_last_r;
  logic [COLOR_WIDTH-1:0]  red_r, green_r, blue_r;
  logic                    out_take;

  // Backpressure chain: a stage loads when it is empty or its content moves on
  always_comb begin
    out_take = !out_vld_r || out_ch.ready;
    take[QB] = !vld_r[QB] || out_take;
    for (int k = QB - 1; k >= 0; k--) begin
      take[k] = !vld_r[k] || take[k+1];
    end
  end

  assign in_ch.ready = take[0];

  logic [SAMPLE_WIDTH-1:0] u_b, lo_b, hi_b;
  logic [SAMPLE_WIDTH:0]   shifted [QB+1];

  always_comb begin
    // First stage: order compare in offset binary, difference and span
    u_b  = SAMPLE_WIDTH'(in_ch.sample) ^ SIGN_BIT;
    lo_b = low_r ^ SIGN_BIT;
    hi_b = high_r ^ SIGN_BIT;
    if (u_b < lo_b) begin
      cls_nxt[0] = CLS_BLUE;
    end else if (u_b >= hi_b || hi_b <= lo_b) begin
      cls_nxt[0] = CLS_RED;
    end else begin
      cls_nxt[0] = CLS_RAMP;
    end
    remv_nxt[0] = u_b - lo_b;
    quo_nxt[0]  = '0;
    rem_nxt[0]  = 1'b0;

    // Restoring division steps, one quotient bit per stage
    shifted[0] = '0;
    for (int k = 1; k <= QB; k++) begin
      shifted[k]  = {rem_r[k-1], 1'b0};
      rem_nxt[k]  = (shifted[k] >= {1'b0, span_r[k-1]});
      remv_nxt[k] = rem_nxt[k] ? SAMPLE_WIDTH'(shifted[k] - {1'b0, span_r[k-1]})
                               : SAMPLE_WIDTH'(shifted[k]);
      quo_nxt[k]  = {quo_r[k-1][QB-2:0], rem_nxt[k]};
      cls_nxt[k]  = cls_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= QB; k++) vld_r[k] <= 1'b0;
    end else begin
      vld_r[0] <= take[0] ? in_ch.valid : vld_r[0];
      for (int k = 1; k <= QB; k++) begin
        if (take[k]) vld_r[k] <= vld_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take[0]) begin
      cls_r[0]  <= cls_nxt[0];
      rem_r[0]  <= remv_nxt[0];
      span_r[0] <= hi_b - lo_b;
      quo_r[0]  <= quo_nxt[0];
      last_r[0] <= in_ch.last_sample;
    end
    for (int k = 1; k <= QB; k++) begin
      if (take[k]) begin
        cls_r[k]  <= cls_nxt[k];
        rem_r[k]  <= remv_nxt[k];
        span_r[k] <= span_r[k-1];
        quo_r[k]  <= quo_nxt[k];
        last_r[k] <= last_r[k-1];
      end
    end
  end

  // Rounded ramp: (255*x + half) >> FRACTION_BITS
  function automatic logic [COLOR_WIDTH-1:0] ramp(input logic [FRACTION_BITS:0] x);
    logic [RW-1:0] xe;
    logic [RW-1:0] prod;
    xe   = RW'(x);
    prod = (xe << COLOR_WIDTH) - xe + HALF;
    return prod[FRACTION_BITS +: COLOR_WIDTH];
  endfunction

  // Color stage
  logic [FRACTION_BITS-1:0] frac;
  logic [1:0]               seg;
  logic [FRACTION_BITS:0]   rise, fall;
  logic [COLOR_WIDTH-1:0]   red_nxt, green_nxt, blue_nxt;

  always_comb begin
    frac = quo_r[QB][FRACTION_BITS-1:0];
    seg  = quo_r[QB][QB-1:FRACTION_BITS];
    rise = {1'b0, frac};
    fall = SEG_ONE - rise;
    red_nxt   = COLOR_NONE;
    green_nxt = COLOR_NONE;
    blue_nxt  = COLOR_NONE;
    case (cls_r[QB])
      CLS_BLUE: blue_nxt = COLOR_FULL;
      CLS_RED:  red_nxt  = COLOR_FULL;
      default: begin
        case (seg)
          2'd0: begin
            green_nxt = ramp(rise);
            blue_nxt  = COLOR_FULL;
          end
          2'd1: begin
            green_nxt = COLOR_FULL;
            blue_nxt  = ramp(fall);
          end
          2'd2: begin
            red_nxt   = ramp(rise);
            green_nxt = COLOR_FULL;
          end
          default: begin
            red_nxt   = COLOR_FULL;
            green_nxt = ramp(fall);
          end
        endcase
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_take) begin
      out_vld_r <= vld_r[QB];
    end
  end

  always_ff @(posedge clk) begin
    if (out_take) begin
      red_r      <= red_nxt;
      green_r    <= green_nxt;
      blue_r     <= blue_nxt;
      out_last_r <= last_r[QB];
    end
  end

  assign out_ch.valid      = out_vld_r;
  assign out_ch.red        = red_r;
  assign out_ch.green      = green_r;
  assign out_ch.blue       = blue_r;
  assign out_ch.last_pixel = out_last_r;

  // Checks
  `SCM_ASSERT_NEXT(a_in_lands, clk, rst_n, in_ch.valid && in_ch.ready, vld_r[0])
  `SCM_ASSERT_NEXT(a_stage0_holds, clk, rst_n, vld_r[0] && !take[1],
                   vld_r[0] && $stable(rem_r[0]) && $stable(cls_r[0]))
  `SCM_ASSERT_NEXT(a_out_from_last_stage, clk, rst_n,
                   out_take && vld_r[QB] && cls_r[QB] == CLS_BLUE,
                   out_ch.valid && out_ch.blue == COLOR_FULL && out_ch.red == COLOR_NONE)

endmodule
